@@ design/gsplit_pkg.sv @@
// ----------------------------------------------------------------------------
// gsplit_pkg
// shared types, constants and helpers of the greedy group splitter
// ----------------------------------------------------------------------------
package gsplit_pkg;

  localparam int VALUE_W      = 32;
  localparam int MAX_VALUES   = 65536;
  localparam int SIZE_W       = 8;
  localparam int WIDTH_W      = 6;
  localparam int COUNT_W      = 17;
  localparam int BYTES_W      = 19;
  localparam int BITS_W       = 22;
  localparam int PROD_W       = SIZE_W + WIDTH_W;
  localparam int SIZE_CFG_W   = 4;
  localparam int WIDTH_CFG_W  = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 88;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BITS = 1'd1;

  localparam logic [SIZE_CFG_W-1:0]  SIZE_BITS_RST  = 4'd6;
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_BITS_RST = 3'd4;

  localparam int GROUPS_CAP_I = (MAX_VALUES < 131071) ? MAX_VALUES : 131071;
  localparam logic [COUNT_W-1:0] GROUPS_CAP = COUNT_W'(GROUPS_CAP_I);
  localparam logic [BITS_W-1:0]  BITS_MAX   = {BITS_W{1'b1}};
  localparam logic [BYTES_W-1:0] BYTES_MAX  = {BYTES_W{1'b1}};
  localparam logic [SIZE_W-1:0]  SIZE_SAT   = {SIZE_W{1'b1}};

  // one closed group handed from front to back
  typedef struct packed {
    logic                last;
    logic [VALUE_W-1:0]  ref_val;
    logic [WIDTH_W-1:0]  width;
    logic [SIZE_W-1:0]   size;
  } grp_rec_t;

  // leading-one position plus one
  function automatic logic [WIDTH_W-1:0] bit_len(input logic [VALUE_W-1:0] d);
    logic [WIDTH_W-1:0] n;
    n = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (d[i]) n = WIDTH_W'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ design/greedy_group_splitter.sv @@
// ----------------------------------------------------------------------------
// greedy_group_splitter
// splits a stream of unsigned values into groups for second-order packing
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one value per transfer; tlast marks the final value of a field
//   m_axis carries one closed group per transfer; tlast marks the final group,
//     which alone carries the group count and the packed byte count
//   cfg writes size_field_bits (index 0) and width_field_bits (index 1);
//     always ready, write only while the stream is idle
// timing
//   one value is accepted every cycle while the queue is not full; the front part
//   tracks min/max and runs the compares, a subtract and a leading-one detect per value
//   a closed group passes from the front into the queue and from the queue into
//   the output register before it shows on m_axis
// stalls
//   a four-entry queue sits between front and back; while m_axis is stalled
//   values keep flowing until the queue fills, then s_axis_tready drops
// reset
//   rst_ni clears the open group, the field totals and the queue, and loads
//   size_field_bits = 6 and width_field_bits = 4; no clearing pass is needed
// ----------------------------------------------------------------------------
module greedy_group_splitter
  import gsplit_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // value stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                   s_axis_tlast,   // last_value
  // group stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // group_size[7:0], group_width[13:8],
                                                 // group_ref[45:14], group_count[62:46],
                                                 // packed_bytes[81:63], zero pad[87:82]
  output logic                   m_axis_tlast    // last_group
);

  grp_rec_t push_rec, head;
  logic     push, pop, q_empty, q_full;

  // registers take every write, so the channel is always ready
  assign cfg_ready_o = 1'b1;

  gsplit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[VALUE_W-1:0]),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .push_rec_o  (push_rec),
    .q_full_i    (q_full)
  );

  // closed groups wait here so the front need not wait on the output side until the queue fills
  gsplit_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // field totals and output register
  gsplit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ design/gsplit_front.sv @@
// ----------------------------------------------------------------------------
// gsplit_front
// accepts values, tracks the open group and decides where groups close
// ----------------------------------------------------------------------------
module gsplit_front
  import gsplit_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_W-1:0]    in_value_i,
  input  logic                  in_last_i,
  output logic                  push_o,
  output grp_rec_t              push_rec_o,
  input  logic                  q_full_i
);

  logic [SIZE_CFG_W-1:0]  size_bits_q;
  logic [WIDTH_CFG_W-1:0] width_bits_q;
  logic [SIZE_CFG_W-1:0]  sb;
  logic [WIDTH_CFG_W-1:0] wb;
  logic [SIZE_W:0]        size_lim;
  logic [WIDTH_W:0]       width_lim;

  logic [VALUE_W-1:0] low_q, high_q, low_d, high_d, diff;
  logic [SIZE_W-1:0]  cnt_q, cnt_d;
  logic [WIDTH_W-1:0] width;
  logic               accept, close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_bits_q  <= SIZE_BITS_RST;
      width_bits_q <= WIDTH_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SIZE_BITS:  size_bits_q  <= cfg_data_i[SIZE_CFG_W-1:0];
        REG_WIDTH_BITS: width_bits_q <= cfg_data_i[WIDTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp register values to their legal ranges and form the size and width limits
  always_comb begin
    sb = size_bits_q;
    if (size_bits_q < 4'd2) sb = 4'd2;
    if (size_bits_q > 4'd8) sb = 4'd8;
    wb = width_bits_q;
    if (width_bits_q < 3'd2) wb = 3'd2;
    if (width_bits_q > 3'd6) wb = 3'd6;
    size_lim  = (9'd1 << sb) - 9'd2;
    width_lim = (7'd1 << wb) - 7'd2;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (cnt_q == '0) begin
      low_d  = in_value_i;
      high_d = in_value_i;
    end else begin
      low_d  = (in_value_i < low_q)  ? in_value_i : low_q;
      high_d = (in_value_i > high_q) ? in_value_i : high_q;
    end
    cnt_d = (cnt_q == SIZE_SAT) ? cnt_q : cnt_q + 8'd1;
    diff  = high_d - low_d;
    width = bit_len(diff);
    close = ({1'b0, cnt_d} > size_lim) || ({1'b0, width} > width_lim) || in_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= close ? '0 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign push_o             = accept && close;
  assign push_rec_o.last    = in_last_i;
  assign push_rec_o.ref_val = low_d;
  assign push_rec_o.width   = width;
  assign push_rec_o.size    = cnt_d;

endmodule

@@ design/gsplit_fifo.sv @@
// ----------------------------------------------------------------------------
// gsplit_fifo
// short queue of closed groups between front and back
// ----------------------------------------------------------------------------
module gsplit_fifo
  import gsplit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  grp_rec_t push_rec_i,
  input  logic     pop_i,
  output grp_rec_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  grp_rec_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

endmodule

@@ design/gsplit_back.sv @@
// ----------------------------------------------------------------------------
// gsplit_back
// accumulates field totals and drives the registered result stream
// ----------------------------------------------------------------------------
module gsplit_back
  import gsplit_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  grp_rec_t               head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_last_o
);

  logic [BITS_W-1:0]  bits_q, bits_d;
  logic [COUNT_W-1:0] groups_q, groups_d;
  logic [PROD_W-1:0]  prod;
  logic [BITS_W:0]    sum;
  logic [BITS_W:0]    round_up;
  logic [BITS_W-3:0]  bytes_raw;
  logic [BYTES_W-1:0] bytes;

  logic                valid_q;
  logic                last_q;
  logic [SIZE_W-1:0]   size_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [VALUE_W-1:0]  ref_q;
  logic [COUNT_W-1:0]  count_q;
  logic [BYTES_W-1:0]  bytes_q;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    prod      = PROD_W'(head_i.size) * PROD_W'(head_i.width);
    sum       = {1'b0, bits_q} + (BITS_W+1)'(prod);
    bits_d    = sum[BITS_W] ? BITS_MAX : sum[BITS_W-1:0];
    groups_d  = (groups_q >= GROUPS_CAP) ? groups_q : groups_q + 1'b1;
    round_up  = {1'b0, bits_d} + (BITS_W+1)'(7);
    bytes_raw = round_up[BITS_W:3];
    bytes     = (bytes_raw > (BITS_W-2)'(BYTES_MAX)) ? BYTES_MAX : bytes_raw[BYTES_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      bits_q   <= '0;
      groups_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        if (head_i.last) begin
          bits_q   <= '0;
          groups_q <= '0;
        end else begin
          bits_q   <= bits_d;
          groups_q <= groups_d;
        end
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      last_q  <= head_i.last;
      size_q  <= head_i.size;
      width_q <= head_i.width;
      ref_q   <= head_i.ref_val;
      count_q <= head_i.last ? groups_d : '0;
      bytes_q <= head_i.last ? bytes : '0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_last_o  = last_q;
  assign out_data_o  = {6'd0, bytes_q, count_q, ref_q, width_q, size_q};

endmodule

@@ design/gsplit_checker.sv @@
// ----------------------------------------------------------------------------
// gsplit_checker
// port-level checks of the greedy group splitter
// ----------------------------------------------------------------------------
module gsplit_checker
  import gsplit_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled group stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("group dropped while stalled");

  // a stalled group keeps its contents
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("group changed while stalled");

  // totals only on the final group
  a_totals_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[81:46] == '0)
    else $error("totals on a non-final group");

  // every group holds at least one value, width fits the value range
  a_group_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:0] != 8'd0 && m_axis_tdata[13:8] <= 6'd32)
    else $error("malformed group");

endmodule

bind greedy_group_splitter gsplit_checker u_gsplit_checker (.*);

@@ sim/greedy_group_splitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_group_splitter_tb
// self-checking bench for the greedy group splitter
// ----------------------------------------------------------------------------
// Values go in through s_axis and closed groups come out of m_axis. A model
// of the block inside the bench predicts every group. It tracks the open
// group's min and max and the per-field totals, and each group on m_axis is
// compared field by field with the oldest prediction.
// The run has these parts, in order:
//   - short directed fields at reset and at clamped register settings
//   - random fields under changing idle patterns on both sides
// ----------------------------------------------------------------------------
module greedy_group_splitter_tb;
  import gsplit_pkg::*;

  localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int unsigned SETTLE_CYCLES = 6;     // output path is two stages deep

  // one predicted group as it should appear on m_axis
  typedef struct {
    logic [SIZE_W-1:0]  size;
    logic [WIDTH_W-1:0] width;
    logic [VALUE_W-1:0] ref_val;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic [BYTES_W-1:0] bytes;
  } group_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] value
  logic                   s_axis_tlast  = 1'b0; // last_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // size, width, ref, count, bytes, pad
  logic                   m_axis_tlast;  // last_group

  // bench copy of the registers and of the splitter state
  logic [SIZE_CFG_W-1:0]  size_bits_reg  = SIZE_BITS_RST;
  logic [WIDTH_CFG_W-1:0] width_bits_reg = WIDTH_BITS_RST;
  logic [VALUE_W-1:0]     open_min       = '0;
  logic [VALUE_W-1:0]     open_max       = '0;
  logic [SIZE_W-1:0]      open_count     = '0;
  logic [BITS_W-1:0]      field_bits     = '0;
  logic [COUNT_W-1:0]     field_groups   = '0;

  group_t      pending_groups[$];
  int unsigned fail_count    = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 47;
  int unsigned quiet_cycles  = 0;

  greedy_group_splitter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // add one value to the open group; queue a group if this value closes it
  function automatic void split_value(input logic [VALUE_W-1:0] v, input logic lst);
    int unsigned       sb;
    int unsigned       wb;
    int unsigned       wdt;
    logic [VALUE_W-1:0] diff;
    longint unsigned   sum;
    longint unsigned   nbytes;
    group_t            g;
    // out-of-range register values are clamped before the limits are formed
    sb = size_bits_reg;
    wb = width_bits_reg;
    if (sb < 2) sb = 2;
    if (sb > 8) sb = 8;
    if (wb < 2) wb = 2;
    if (wb > 6) wb = 6;
    if (open_count == 0) begin
      open_min = v;
      open_max = v;
    end else begin
      if (v < open_min) open_min = v;
      if (v > open_max) open_max = v;
    end
    if (open_count != SIZE_SAT) open_count++;
    diff = open_max - open_min;
    wdt  = 0;
    while (diff != '0) begin
      diff = diff >> 1;
      wdt++;
    end
    if (open_count <= (1 << sb) - 2 && wdt <= (1 << wb) - 2 && !lst) return;
    // group closes here, the closing value included
    if (field_groups < GROUPS_CAP) field_groups++;
    sum = longint'(field_bits) + longint'(open_count) * wdt;
    if (sum > BITS_MAX) sum = BITS_MAX;
    field_bits = BITS_W'(sum);
    g.size    = open_count;
    g.width   = WIDTH_W'(wdt);
    g.ref_val = open_min;
    g.last    = lst;
    g.count   = '0;
    g.bytes   = '0;
    if (lst) begin
      nbytes = (longint'(field_bits) + 7) / 8;
      if (nbytes > BYTES_MAX) nbytes = BYTES_MAX;
      g.count      = field_groups;
      g.bytes      = BYTES_W'(nbytes);
      field_bits   = '0;
      field_groups = '0;
    end
    open_count = '0;
    open_min   = '0;
    open_max   = '0;
    pending_groups.push_back(g);
  endfunction

  // one value transfer, with a random gap ahead of it
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    split_value(v, lst);
  endtask

  // hold the value stream until every predicted group has come out
  task automatic wait_groups_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_groups.size() != 0);
  endtask

  // register write, only with the stream quiet and the output path empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_groups_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SIZE_BITS) size_bits_reg = data[SIZE_CFG_W-1:0];
    else width_bits_reg = data[WIDTH_CFG_W-1:0];
  endtask

  task automatic compare_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // reset settings: single-value field, full-range width, width just at the limit
  task automatic test_field_basics();
    send_value(32'h0000_0000, 1'b1);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_0000, 1'b0);   // width 32 closes the group
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h8000_3FFF, 1'b0);   // width 14, still open
    wait_groups_drained();             // pause mid-field with a group open
    send_value(32'h8000_4000, 1'b1);   // width 15 and last together
    send_value(32'h1234_5678, 1'b1);   // new field starts from clean totals
  endtask

  // register values below and above the legal range are clamped
  task automatic test_register_clamping();
    write_reg(REG_SIZE_BITS, 4'd0);
    write_reg(REG_WIDTH_BITS, 4'd0);
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);           // size 3 over the limit of 2
    send_value(32'd5, 1'b0);
    send_value(32'd9, 1'b0);           // width 3 over the limit of 2
    send_value(32'd7, 1'b1);
    write_reg(REG_SIZE_BITS, 4'd15);
    write_reg(REG_WIDTH_BITS, 4'd15);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b1);
    write_reg(REG_SIZE_BITS, 4'd1);
    write_reg(REG_WIDTH_BITS, 4'd1);
    send_value(32'd3, 1'b0);
    send_value(32'd3, 1'b0);
    send_value(32'd3, 1'b0);
    send_value(32'd3, 1'b1);
  endtask

  // random fields: clustered values with a spread that drifts, a few strays,
  // register changes between fields
  task automatic test_random_fields(input int unsigned budget);
    int unsigned        sent;
    int unsigned        field_len;
    int unsigned        spread;
    int unsigned        i;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] v;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_WIDTH_BITS : REG_SIZE_BITS,
                  CFG_DATA_W'($urandom_range(15)));
      field_len = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(80, 1);
      spread    = $urandom_range(32);
      base      = $urandom;
      for (i = 0; i < field_len; i++) begin
        mask = (spread >= 32) ? '1 : (VALUE_W'(1) << spread) - 1'b1;
        if ($urandom_range(39) == 0) v = $urandom;
        else v = base + ($urandom & mask);
        if ($urandom_range(29) == 0) spread = $urandom_range(32);
        if (i == field_len / 2 && $urandom_range(9) == 0) wait_groups_drained();
        send_value(v, i == field_len - 1);
      end
      sent += field_len;
    end
  endtask

  // group receiver: random stalls, each transfer checked against the oldest prediction
  always @(posedge clk_i) begin : check_groups
    group_t g;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_groups.size() == 0) begin
        $display("%0t: unexpected group, expected none, got tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        g = pending_groups.pop_front();
        compare_field("group_size",   g.size,    m_axis_tdata[7:0]);
        compare_field("group_width",  g.width,   m_axis_tdata[13:8]);
        compare_field("group_ref",    g.ref_val, m_axis_tdata[45:14]);
        compare_field("group_count",  g.count,   m_axis_tdata[62:46]);
        compare_field("packed_bytes", g.bytes,   m_axis_tdata[81:63]);
        compare_field("tdata pad",    0,         m_axis_tdata[87:82]);
        compare_field("last_group",   g.last,    m_axis_tlast);
      end
    end
  end

  // watchdog: too long with no transfer on any channel ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_basics();
    test_register_clamping();
    test_random_fields(480);
    // swap the idle pattern, then run with no idling at all
    send_idle_pct = 47;
    recv_idle_pct = 28;
    test_random_fields(480);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_fields(480);
    wait_groups_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
